// ----- sv/tdsh_pkg.sv -----
// Package for the disc identifier SHA-1 hasher: payload types, constants and helpers.
// No dependencies.
package tdsh_pkg;

	localparam int SlotCount = 100;
	localparam int IdChars = 28;
	localparam int CfgWidth = 16;
	localparam int CfgIdxWidth = 2;

	localparam logic [CfgIdxWidth-1:0] CFG_FIRST_TRACK = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_LAST_TRACK = 2'd1;
	localparam logic [CfgIdxWidth-1:0] CFG_LEAD_IN = 2'd2;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	// Padded message is 832 bytes: 804 data, 0x80, zeros, 64-bit length.
	localparam int MsgBytes = 804;
	localparam int PadBytes = 832;
	localparam logic [63:0] MSG_BITS = 64'd6432;

	typedef struct packed {
		logic [23:0] frame_offset;
		logic        last_entry;
	} toc_item_t;

	typedef struct packed {
		logic [6:0] id_char;
		logic       last_char;
	} id_item_t;

	// Uppercase hex digit for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
	endfunction

	// Modified base64 alphabet.
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) c = 7'h41 + {1'b0, v};
		else if (v < 6'd52) c = 7'h61 + {1'b0, v} - 7'd26;
		else if (v < 6'd62) c = 7'h30 + {1'b0, v} - 7'd52;
		else if (v == 6'd62) c = 7'h2E;
		else c = 7'h5F;
		b64_char = c;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ----- sv/tdsh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tdsh_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/tdsh_core.sv -----
// SHA-1 compression engine: rounds run in turn over a 16-word schedule memory.
// Depends on tdsh_pkg and tdsh_ram.
module tdsh_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init,
	input  logic        wr_en,
	input  logic [3:0]  wr_addr,
	input  logic [31:0] wr_data,
	input  logic        start,
	output logic        busy,
	output logic [159:0] digest
);
	import tdsh_pkg::*;

	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        run_q;
	logic [2:0]  sub_q;
	logic [31:0] acc_q;

	logic        we;
	logic [3:0]  waddr, raddr;
	logic [31:0] wdata, rdata;

	// Each round reads the three schedule taps in turn, then w[t-16], and computes once
	// that last read returns. The word w[t] replaces w[t-16] in place.
	tdsh_ram #(.Width(32), .Depth(16)) u_wmem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [3:0] t4;
	assign t4 = rnd_q[3:0];

	always_comb begin
		case (sub_q)
			3'd0: raddr = t4 + 4'd13;
			3'd1: raddr = t4 + 4'd8;
			3'd2: raddr = t4 + 4'd2;
			default: raddr = t4;
		endcase
	end

	logic [31:0] w_new, w_use, f, k, t;
	assign w_new = rotl(acc_q ^ rdata, 1);
	assign w_use = (rnd_q < 7'd16) ? rdata : w_new;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
	end
	assign t = rotl(a_q, 5) + f + e_q + k + w_use;

	logic last_sub;
	assign last_sub = run_q && (sub_q == 3'd4);

	assign we = run_q ? (last_sub && rnd_q >= 7'd16) : wr_en;
	assign waddr = run_q ? t4 : wr_addr;
	assign wdata = run_q ? w_new : wr_data;
	assign busy = run_q;
	assign digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

	// Round sequencer and chaining update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0; sub_q <= '0; rnd_q <= '0;
			h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
		end else if (init) begin
			h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
		end else if (start && !run_q) begin
			run_q <= 1'b1; sub_q <= '0; rnd_q <= '0;
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end else if (run_q) begin
			sub_q <= last_sub ? 3'd0 : sub_q + 3'd1;
			if (sub_q == 3'd1) acc_q <= rdata;
			else if (sub_q == 3'd2 || sub_q == 3'd3) acc_q <= acc_q ^ rdata;
			if (last_sub) begin
				e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= t;
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd79) begin
					run_q <= 1'b0;
					h_q[0] <= h_q[0] + t; h_q[1] <= h_q[1] + a_q;
					h_q[2] <= h_q[2] + rotl(b_q, 30);
					h_q[3] <= h_q[3] + c_q; h_q[4] <= h_q[4] + d_q;
				end
			end
		end
	end
endmodule

// ----- sv/toc_disc_id_sha1_hasher_unit.sv -----
// Top level of the disc identifier hasher: message builder, padding and base64 output.
// Depends on tdsh_pkg and tdsh_core.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/ready   | toc_item_t
//   out     | output    | out_valid/ready  | id_item_t
//   cfg     | input     | cfg_we           | cfg_idx, cfg_data
//
// After its transfer an item passes a load step, eight byte steps and a closing load step
// before the next transfer is possible; the first item of a table adds four header bytes
// and one more load step. Each filled 64-byte block adds a wait in the hash state for the
// compression (80 rounds, four schedule memory reads per round, then a step to resume).
// The flagged item then fills the remaining slots and padding (13 blocks in all per table)
// before 28 characters leave, one per accepted output transfer.
// Reset restores the initial hash and counts.
// Input waits while a table is being built or emitted; output stalls hold the character.
module toc_disc_id_sha1_hasher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tdsh_pkg::toc_item_t             in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tdsh_pkg::id_item_t              out_data,
	input  logic                            cfg_we,
	input  logic [tdsh_pkg::CfgIdxWidth-1:0] cfg_idx,
	input  logic [tdsh_pkg::CfgWidth-1:0]   cfg_data
);
	import tdsh_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_BYTE = 5'b00010,
		ST_HASH = 5'b00100,
		ST_EMIT = 5'b01000,
		ST_LOAD = 5'b10000
	} state_t;

	state_t      state_q;
	logic [6:0]  first_q, last_q;
	logic [15:0] lead_q;
	logic [6:0]  entry_q;
	logic [9:0]  pos_q;      // message byte position
	logic [3:0]  nbytes_q;   // bytes still to put for current chunk
	logic [31:0] val_q;
	logic [31:0] off0_q;     // first offset of a table, sent after the header
	logic        hdr_q, fin_q;
	logic [31:0] word_q;
	logic [4:0]  oidx_q;
	logic [167:0] dig_q;

	logic        core_busy, core_start, core_init;
	logic [159:0] digest;
	logic        wr_en;

	// Current byte: hex data, pad marker, zero or length.
	logic [7:0] cur_byte;
	always_comb begin
		if (!fin_q || pos_q < 10'(MsgBytes)) begin
			cur_byte = hex_char(val_q[31:28]);
		end else if (pos_q == 10'(MsgBytes)) begin
			cur_byte = 8'h80;
		end else if (pos_q >= 10'(PadBytes - 8)) begin
			cur_byte = MSG_BITS[8*(7 - int'(pos_q[2:0])) +: 8];
		end else begin
			cur_byte = 8'h00;
		end
	end

	logic [31:0] word_next;
	assign word_next = {word_q[23:0], cur_byte};
	assign wr_en = (state_q == ST_BYTE) && (pos_q[1:0] == 2'd3);
	assign core_start = (state_q == ST_BYTE) && (pos_q[5:0] == 6'd63);
	assign core_init = (state_q == ST_EMIT) && out_valid && out_ready && oidx_q == 5'd27;

	tdsh_core u_core (
		.clk(clk), .arst_n(arst_n), .init(core_init), .wr_en(wr_en),
		.wr_addr(pos_q[5:2]), .wr_data(word_next), .start(core_start),
		.busy(core_busy), .digest(digest)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_data.id_char = (oidx_q == 5'd27) ? 7'h2D : b64_char(dig_q[167:162]);
	assign out_data.last_char = (oidx_q == 5'd27);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 7'd1; last_q <= 7'd0; lead_q <= 16'd150;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_FIRST_TRACK: first_q <= cfg_data[6:0];
				CFG_LAST_TRACK:  last_q <= cfg_data[6:0];
				CFG_LEAD_IN:     lead_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Message sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; entry_q <= '0; pos_q <= '0; nbytes_q <= '0;
			hdr_q <= 1'b0; fin_q <= 1'b0; oidx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fin_q <= in_data.last_entry;
						if (entry_q == 7'd0) begin
							val_q <= {1'b0, first_q, 1'b0, last_q, 16'd0};
							nbytes_q <= 4'd4; hdr_q <= 1'b1;
						end else begin
							val_q <= {8'd0, in_data.frame_offset} + {16'd0, lead_q};
							nbytes_q <= (entry_q < 7'(SlotCount)) ? 4'd8 : 4'd0;
							hdr_q <= 1'b0;
						end
						if (entry_q == 7'd0)
							off0_q <= {8'd0, in_data.frame_offset} + {16'd0, lead_q};
						if (entry_q < 7'(SlotCount)) entry_q <= entry_q + 7'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (nbytes_q != 4'd0) state_q <= ST_BYTE;
					else if (hdr_q) begin
						// Header done; now the first offset kept in off0_q.
						val_q <= off0_q; nbytes_q <= 4'd8; hdr_q <= 1'b0;
						state_q <= ST_BYTE;
					end else if (fin_q && pos_q < 10'(MsgBytes) && entry_q < 7'(SlotCount)) begin
						val_q <= '0; nbytes_q <= 4'd8; entry_q <= entry_q + 7'd1;
						state_q <= ST_BYTE;
					end else if (fin_q && pos_q < 10'(MsgBytes)) begin
						val_q <= '0; nbytes_q <= 4'd8; state_q <= ST_BYTE;
					end else if (fin_q && pos_q != 10'(PadBytes) && pos_q != 10'd0) begin
						nbytes_q <= 4'd1; state_q <= ST_BYTE;
					end else if (fin_q) begin
						dig_q <= {digest, 8'd0}; oidx_q <= '0; state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BYTE: begin
					word_q <= word_next;
					val_q <= {val_q[27:0], 4'd0};
					pos_q <= pos_q + 10'd1;
					nbytes_q <= nbytes_q - 4'd1;
					if (core_start) state_q <= ST_HASH;
					else if (nbytes_q == 4'd1) state_q <= ST_LOAD;
				end
				ST_HASH: begin
					if (!core_busy) begin
						if (pos_q == 10'(PadBytes)) begin
							dig_q <= {digest, 8'd0}; oidx_q <= '0; state_q <= ST_EMIT;
						end else begin
							state_q <= (nbytes_q != 4'd0) ? ST_BYTE : ST_LOAD;
						end
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						dig_q <= {dig_q[161:0], 6'd0};
						oidx_q <= oidx_q + 5'd1;
						if (oidx_q == 5'd27) begin
							state_q <= ST_IDLE; entry_q <= '0; pos_q <= '0; fin_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on the sequencer.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open during output");
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last_char) |=> in_ready)
		else $error("no return to idle after last character");
	a_core_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		core_busy |-> !wr_en) else $error("schedule write during compression");
endmodule

// ----- dv/testbench.sv -----
// Testbench for the disc identifier SHA-1 hasher: directed and random tables of contents
// checked character by character against a SHA-1 and base64 predictor built in here.
// Depends on tdsh_pkg and toc_disc_id_sha1_hasher_unit.
`timescale 1ns / 1ps

module testbench;
	import tdsh_pkg::*;

	localparam int IdleLimit = 60000;
	localparam int SettleCycles = 40;
	localparam string IdAlphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	toc_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	id_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CfgIdxWidth-1:0] cfg_idx = CFG_FIRST_TRACK;
	logic [CfgWidth-1:0] cfg_data = '0;

	toc_disc_id_sha1_hasher_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: chaining words, current block, counts and register copies.
	logic [31:0] chain[5];
	logic [31:0] block_buf[16];
	int slots_taken;
	int bytes_in_block;
	logic [12:0] msg_len;
	logic [6:0] first_trk;
	logic [6:0] last_trk;
	logic [15:0] lead_frames;

	id_item_t id_queue[$];
	int error_count = 0;
	int entries_sent = 0;
	int tables_done = 0;
	int chars_seen = 0;
	bit calm = 1'b0;
	int idle_cycles = 0;

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// One 80-round SHA-1 compression of the current block into the chaining words.
	task automatic compress_block_words();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) w[i] = block_buf[i];
		for (int i = 16; i < 80; i++)
			w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rot_left(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rot_left(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	// Bytes pack big-endian into the block; a full block is compressed at once.
	task automatic append_byte(input logic [7:0] octet);
		int idx;
		int sh;
		idx = bytes_in_block / 4;
		sh = (3 - bytes_in_block % 4) * 8;
		if (bytes_in_block % 4 == 0) block_buf[idx] = 32'(octet) << sh;
		else block_buf[idx] |= 32'(octet) << sh;
		bytes_in_block++;
		if (bytes_in_block == 64) begin
			compress_block_words();
			bytes_in_block = 0;
		end
	endtask

	task automatic append_hex(input logic [31:0] value, input int digits);
		logic [3:0] nib;
		for (int i = digits; i > 0; i--) begin
			nib = value[(i-1)*4 +: 4];
			append_byte(nib < 4'd10 ? 8'h30 + nib : 8'h37 + nib);
		end
		msg_len += 13'(digits);
	endtask

	task automatic clear_table();
		chain[0] = H0_INIT; chain[1] = H1_INIT; chain[2] = H2_INIT;
		chain[3] = H3_INIT; chain[4] = H4_INIT;
		foreach (block_buf[i]) block_buf[i] = '0;
		slots_taken = 0;
		bytes_in_block = 0;
		msg_len = '0;
	endtask

	// Adds one accepted table entry; a flagged entry pads, hashes and queues 28 characters.
	task automatic absorb_entry(input toc_item_t item);
		logic [63:0] bit_len;
		logic [7:0] digest[21];
		logic [23:0] grp;
		bit full;
		id_item_t ch;
		if (slots_taken == 0) begin
			append_hex(32'(first_trk), 2);
			append_hex(32'(last_trk), 2);
		end
		if (slots_taken < SlotCount) begin
			append_hex(32'(item.frame_offset) + 32'(lead_frames), 8);
			slots_taken++;
		end
		if (!item.last_entry) return;
		while (slots_taken < SlotCount) begin
			append_hex(32'd0, 8);
			slots_taken++;
		end
		bit_len = 64'(msg_len) * 8;
		append_byte(8'h80);
		while (bytes_in_block != 56) append_byte(8'h00);
		for (int i = 7; i >= 0; i--) append_byte(bit_len[i*8 +: 8]);
		for (int i = 0; i < 20; i++) digest[i] = chain[i/4][(3 - i%4)*8 +: 8];
		digest[20] = 8'h00;
		for (int i = 0; i < 20; i += 3) begin
			full = (i + 2) < 20;
			grp = {digest[i], digest[i+1], full ? digest[i+2] : 8'h00};
			for (int j = 0; j < 4; j++) begin
				if (j == 3 && !full) ch.id_char = 7'h2D;
				else ch.id_char = 7'(IdAlphabet[grp[(3-j)*6 +: 6]]);
				ch.last_char = (id_queue.size() % IdChars) == IdChars - 1;
				id_queue = {id_queue, ch};
			end
		end
		clear_table();
	endtask

	// Register writes; only called while the block is idle.
	task automatic set_registers(input logic [6:0] ft, input logic [6:0] lt,
			input logic [15:0] li);
		cfg_we <= 1'b1; cfg_idx <= CFG_FIRST_TRACK; cfg_data <= CfgWidth'(ft);
		@(posedge clk);
		cfg_idx <= CFG_LAST_TRACK; cfg_data <= CfgWidth'(lt);
		@(posedge clk);
		cfg_idx <= CFG_LEAD_IN; cfg_data <= li;
		@(posedge clk);
		cfg_we <= 1'b0;
		first_trk = ft; last_trk = lt; lead_frames = li;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (id_queue.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Offers one entry after a random gap, none while calm, and returns at the edge of its transfer.
	task automatic send_entry(input logic [23:0] offset, input bit last);
		int gap;
		toc_item_t item;
		gap = calm ? 0 : $urandom_range(0, 10);
		item.frame_offset = offset;
		item.last_entry = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		absorb_entry(item);
		entries_sent++;
		if (last) tables_done++;
	endtask

	// Directed rows: a register set may only lead a row that starts a table.
	typedef struct packed {
		bit reload;
		logic [6:0] ft;
		logic [6:0] lt;
		logic [15:0] li;
		logic [23:0] offset;
		bit last;
	} script_row_t;

	script_row_t script[12] = '{
		'{1'b0, 7'd1, 7'd0, 16'd150, 24'h000000, 1'b1},
		'{1'b1, 7'd0, 7'd0, 16'd0, 24'hFFFFFF, 1'b0},
		'{1'b0, 7'd0, 7'd0, 16'd0, 24'h000000, 1'b0},
		'{1'b0, 7'd0, 7'd0, 16'd0, 24'h123456, 1'b1},
		'{1'b1, 7'd127, 7'd127, 16'hFFFF, 24'hFFFFFF, 1'b1},
		'{1'b1, 7'd99, 7'd99, 16'd150, 24'h0001C2, 1'b0},
		'{1'b0, 7'd99, 7'd99, 16'd150, 24'h00A5A5, 1'b0},
		'{1'b0, 7'd99, 7'd99, 16'd150, 24'h5A5A5A, 1'b1},
		'{1'b0, 7'd99, 7'd99, 16'd150, 24'hA5A5A5, 1'b1},
		'{1'b1, 7'd1, 7'd12, 16'd150, 24'h03FA2B, 1'b0},
		'{1'b0, 7'd1, 7'd12, 16'd150, 24'h000096, 1'b0},
		'{1'b0, 7'd1, 7'd12, 16'd150, 24'h001234, 1'b1}
	};

	// Stimulus: reset, the directed rows, then random tables.
	initial begin
		int len;
		int tab;
		first_trk = 7'd1; last_trk = 7'd0; lead_frames = 16'd150;
		clear_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[r]) begin
			if (script[r].reload) begin
				wait_idle();
				set_registers(script[r].ft, script[r].lt, script[r].li);
			end
			send_entry(script[r].offset, script[r].last);
		end
		tab = 0;
		while (entries_sent < 160) begin
			if (tab % 4 == 1) begin
				wait_idle();
				case ($urandom_range(0, 2))
					0: set_registers(7'd0, 7'd127, 16'hFFFF);
					1: set_registers(7'd127, 7'd0, 16'd0);
					default: set_registers(7'($urandom_range(0, 127)),
						7'($urandom_range(0, 127)), 16'($urandom));
				endcase
			end
			calm = (tab % 5 == 3);
			// One long table runs past the slot count so excess entries are dropped.
			len = (tab == 2) ? SlotCount + 4 : $urandom_range(1, 8);
			for (int i = 1; i <= len; i++)
				send_entry(24'($urandom), i == len);
			tab++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		while (id_queue.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		$display("Sent %0d entries in %0d tables; checked %0d identifier characters.",
			entries_sent, tables_done, chars_seen);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stalls, one long hold-off while the sender keeps offering.
	// The hold-off falls in the eighth table, which is followed by a table with no
	// register set, so the next entry waits at the input the whole time.
	initial begin
		int gap;
		bit held = 1'b0;
		id_item_t want;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 10);
			if (!held && chars_seen == 7 * IdChars + 3) begin
				held = 1'b1;
				gap = 800;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			chars_seen++;
			if (id_queue.size() == 0) begin
				$error("unexpected character transfer: id_char %h", out_data.id_char);
				error_count++;
			end else begin
				want = id_queue.pop_front();
				if (out_data.id_char !== want.id_char) begin
					$error("id_char: expected %h, got %h", want.id_char, out_data.id_char);
					error_count++;
				end
				if (out_data.last_char !== want.last_char) begin
					$error("last_char: expected %b, got %b", want.last_char,
						out_data.last_char);
					error_count++;
				end
			end
		end
	end

	// Watchdog on stretches with no transfer on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
